// ----- design/pht_pkg.sv -----
package pht_pkg;
	localparam int unsigned DEF_MAX_PIXELS   = 1048576;
	localparam int unsigned DEF_PEAK_RANGE   = 200;
	localparam int unsigned DEF_MAX_DISTANCE = 32;
	localparam int unsigned FIRST_DISTANCE   = 2;
	localparam int unsigned RATIO_LIMIT      = 65535;
	localparam int unsigned PIXEL_W          = 8;
	localparam int unsigned BINS             = 256;
	localparam int unsigned DIST_W           = 5;

	// controller to datapath
	typedef struct packed {
		logic clr_start;   // zero sweep address
		logic clr_write;   // write zero at sweep address
		logic pk1_start;   // begin first peak scan
		logic pk2_start;   // begin second peak scan for current distance
		logic val_start;   // begin valley scan
		logic rate;        // evaluate candidate ratio
		logic dist_next;   // step distance
		logic ana_init;    // clear best result, set distance to FIRST_DISTANCE
	} pht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic clr_done;
		logic dist_last;
	} pht_sts_t;
endpackage

// ----- design/pht_ram.sv -----
module pht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- design/pht_datapath.sv -----
module pht_datapath #(
	parameter int unsigned MAX_PIXELS   = pht_pkg::DEF_MAX_PIXELS,
	parameter int unsigned PEAK_RANGE   = pht_pkg::DEF_PEAK_RANGE,
	parameter int unsigned MAX_DISTANCE = pht_pkg::DEF_MAX_DISTANCE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_ok,
	input  logic [7:0]                 pixel_value,
	input  pht_pkg::pht_cmd_t          cmd,
	output pht_pkg::pht_sts_t          sts,
	output logic                       busy_pix,
	output logic [7:0]                 thr,
	output logic [$clog2(MAX_DISTANCE)-1:0] dist_out
);
	import pht_pkg::*;

	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned DW = $clog2(MAX_DISTANCE);
	localparam int unsigned AW = 8;
	localparam int unsigned PW = 2 * CW + 17;

	// scan modes
	localparam logic [1:0] M_PK1 = 2'd0;
	localparam logic [1:0] M_PK2 = 2'd1;
	localparam logic [1:0] M_VAL = 2'd2;

	logic [CW-1:0] total_q;
	logic [CW-1:0] rdata;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [CW-1:0] wdata;

	// pixel read-modify-write: read in one cycle, write in the next
	logic          acc_s1;
	logic [AW-1:0] acc_a_s1;
	logic          fwd;
	logic [CW-1:0] cur;

	// scan engine
	logic          scan_q, rd_v_q;
	logic [1:0]    mode_q;
	logic [8:0]    sa_q, send_q;
	logic [AW-1:0] rd_a_q;
	logic [CW-1:0] pk1_q, pk2_q, low_q;
	logic [AW-1:0] pk1_at_q, pk2_at_q, valley_at_q;
	logic [DW-1:0] dist_q;
	logic [CW-1:0] clr_a_q;
	logic          clr_done_q;
	logic [PW-1:0] bnum_q, bden_q;
	logic [PW-1:0] p1_s1, p2_s1;
	logic          ok_s1, rate_s1;
	logic [CW-1:0] num_c, den_c;
	logic [9:0]    lo_c, hi_c;

	// second-peak exclusion range around the first peak
	assign lo_c = {2'b0, pk1_at_q} - 10'(dist_q) + 10'd1;
	assign hi_c = {2'b0, pk1_at_q} + 10'(dist_q);

	always_comb begin
		if (cmd.clr_write) begin
			we = 1'b1; waddr = clr_a_q[AW-1:0]; wdata = '0;
		end else begin
			we = acc_s1; waddr = acc_a_s1; wdata = cur + CW'(1);
		end
	end
	assign fwd = pix_ok && acc_s1 && acc_a_s1 == pixel_value;
	assign cur = rdata;
	assign raddr = scan_q ? sa_q[AW-1:0] : pixel_value;
	assign busy_pix = acc_s1;

	pht_ram #(.WIDTH(CW), .DEPTH(BINS)) u_bins (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0; total_q <= '0; scan_q <= 1'b0; rd_v_q <= 1'b0;
			clr_a_q <= '0; clr_done_q <= 1'b0; rate_s1 <= 1'b0;
		end else begin
			acc_s1 <= pix_ok && !fwd && total_q < CW'(MAX_PIXELS);
			if (pix_ok && !fwd && total_q < CW'(MAX_PIXELS))
				total_q <= total_q + CW'(1);
			if (cmd.clr_start) begin
				clr_a_q <= '0; clr_done_q <= 1'b0;
			end else if (cmd.clr_write) begin
				clr_a_q <= clr_a_q + CW'(1);
				clr_done_q <= clr_a_q[AW-1:0] == AW'(BINS - 2);
				if (clr_a_q[AW-1:0] == AW'(BINS - 1))
					total_q <= '0;
			end
			rd_v_q <= scan_q && sa_q < send_q;
			if (cmd.pk1_start || cmd.pk2_start || cmd.val_start)
				scan_q <= 1'b1;
			else if (scan_q && sa_q >= send_q)
				scan_q <= 1'b0;
			rate_s1 <= cmd.rate;
		end
	end

	always_ff @(posedge clk) begin
		acc_a_s1 <= pixel_value;
		rd_a_q <= sa_q[AW-1:0];
		if (cmd.pk1_start) begin
			mode_q <= M_PK1; sa_q <= '0; send_q <= 9'(PEAK_RANGE);
			pk1_q <= '0; pk1_at_q <= '0;
		end else if (cmd.pk2_start) begin
			mode_q <= M_PK2; sa_q <= '0; send_q <= 9'(PEAK_RANGE);
			pk2_q <= '0; pk2_at_q <= '0;
		end else if (cmd.val_start) begin
			mode_q <= M_VAL; low_q <= total_q;
			sa_q <= {1'b0, (pk1_at_q < pk2_at_q) ? pk1_at_q : pk2_at_q};
			send_q <= {1'b0, (pk1_at_q < pk2_at_q) ? pk2_at_q : pk1_at_q};
		end else if (scan_q && sa_q < send_q)
			sa_q <= sa_q + 9'd1;
		// lo_c negative: every level below the first peak is inside the exclusion
		if (rd_v_q) begin
			unique case (mode_q)
				M_PK1: if (rdata > pk1_q) begin
					pk1_q <= rdata; pk1_at_q <= rd_a_q;
				end
				M_PK2: if (!((lo_c[9] || {2'b0, rd_a_q} >= lo_c)
						&& {2'b0, rd_a_q} < hi_c) && rdata > pk2_q) begin
					pk2_q <= rdata; pk2_at_q <= rd_a_q;
				end
				M_VAL: if (rdata < low_q) begin
					low_q <= rdata; valley_at_q <= rd_a_q;
				end
				default: ;
			endcase
		end
		if (cmd.ana_init) begin
			bnum_q <= '0; bden_q <= PW'(1); thr <= '0; dist_out <= '0;
			dist_q <= DW'(FIRST_DISTANCE); valley_at_q <= '0;
		end else if (cmd.dist_next)
			dist_q <= dist_q + DW'(1);
		// ratio compare: products registered, decision next cycle
		if (cmd.rate) begin
			p1_s1 <= PW'(num_c) * bden_q[CW-1:0];
			p2_s1 <= bnum_q[CW-1:0] * PW'(den_c);
			ok_s1 <= num_c != '0 && PW'(num_c) < PW'(den_c) * PW'(RATIO_LIMIT);
		end
		if (rate_s1 && ok_s1 && p1_s1 > p2_s1) begin
			bnum_q <= PW'(num_c); bden_q <= PW'(den_c);
			thr <= valley_at_q; dist_out <= dist_q;
		end
	end

	assign num_c = (pk1_q < pk2_q) ? pk1_q : pk2_q;
	assign den_c = (low_q == '0) ? CW'(1) : low_q;

	assign sts.scan_done = !scan_q && !rd_v_q;
	assign sts.clr_done  = clr_done_q;
	assign sts.dist_last = dist_q == DW'(MAX_DISTANCE - 1);
endmodule

// ----- design/pht_ctrl.sv -----
module pht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_take,
	input  logic              end_of_frame,
	input  logic              out_ready,
	input  logic              busy_pix,
	input  pht_pkg::pht_sts_t sts,
	output pht_pkg::pht_cmd_t cmd,
	output logic              accepting,
	output logic              res_valid
);
	import pht_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_RUN  = 4'd1;
	localparam logic [3:0] S_PK1  = 4'd2;
	localparam logic [3:0] S_PK2  = 4'd3;
	localparam logic [3:0] S_VAL  = 4'd4;
	localparam logic [3:0] S_RATE = 4'd5;
	localparam logic [3:0] S_CMP  = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;
	localparam logic [3:0] S_WAIT = 4'd8;
	localparam logic [3:0] S_W1   = 4'd9;
	localparam logic [3:0] S_W2   = 4'd10;
	localparam logic [3:0] S_W3   = 4'd11;

	logic [3:0] state_q, nxt;
	logic       first_q;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_done) nxt = S_RUN;
			end
			S_RUN: if (in_take && end_of_frame) nxt = S_WAIT;
			S_WAIT: if (!busy_pix) begin
				cmd.pk1_start = 1'b1; cmd.ana_init = 1'b1; nxt = S_W1;
			end
			S_W1: nxt = S_PK1;
			S_PK1: if (sts.scan_done) begin
				cmd.pk2_start = 1'b1; nxt = S_W2;
			end
			S_W2: nxt = S_PK2;
			S_PK2: if (sts.scan_done) begin
				cmd.val_start = 1'b1; nxt = S_W3;
			end
			S_W3: nxt = S_VAL;
			S_VAL: if (sts.scan_done) begin
				cmd.rate = 1'b1; nxt = S_RATE;
			end
			S_RATE: nxt = S_CMP;
			S_CMP: if (sts.dist_last) nxt = S_OUT;
			else begin
				cmd.dist_next = 1'b1; cmd.pk2_start = 1'b1; nxt = S_W2;
			end
			S_OUT: if (out_ready) begin
				cmd.clr_start = 1'b1; nxt = S_CLR;
			end
			default: nxt = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; first_q <= 1'b1;
		end else begin
			state_q <= nxt; first_q <= 1'b0;
		end
	end

	assign accepting = state_q == S_RUN && !first_q;
	assign res_valid = state_q == S_OUT;
endmodule

// ----- design/peakiness_histogram_threshold_core.sv -----
// peakiness histogram threshold
// in channel: pixel_value with end_of_frame, valid/ready; every accepted
//   pixel that is counted (fewer than MAX_PIXELS so far) holds in_ready low
//   for the following cycle while a frame is being collected
// out channel: threshold and distance_used, valid/ready; one transfer per
//   frame, after the pixel that carries end_of_frame
// pixels land in a 256-entry bin memory through a read-modify-write pipe
// analysis: one first-peak scan over the peak range, then per distance a
//   second-peak scan and a valley scan, each one bin per cycle through the
//   single read port; out_valid rises once the last distance is rated
// the result sits in registers until the receiver takes it; in is held off
//   meanwhile, then a clearing pass zeroes the bins
// reset starts that same clearing pass before the first pixel
module peakiness_histogram_threshold_core #(
	parameter int unsigned MAX_PIXELS   = pht_pkg::DEF_MAX_PIXELS,
	parameter int unsigned PEAK_RANGE   = pht_pkg::DEF_PEAK_RANGE,
	parameter int unsigned MAX_DISTANCE = pht_pkg::DEF_MAX_DISTANCE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_value,
	input  logic       end_of_frame,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] threshold,
	output logic [4:0] distance_used
);
	import pht_pkg::*;

	pht_cmd_t cmd;
	pht_sts_t sts;
	logic     accepting, busy_pix, take, fwd_hold;
	logic [$clog2(MAX_DISTANCE)-1:0] dist_w;

	// same-level pixel right behind another would read a stale bin
	assign fwd_hold = busy_pix;
	assign in_ready = accepting && !fwd_hold;
	assign take = in_valid && in_ready;

	pht_datapath #(.MAX_PIXELS(MAX_PIXELS), .PEAK_RANGE(PEAK_RANGE),
		.MAX_DISTANCE(MAX_DISTANCE)) u_dp (
		.clk(clk), .arst_n(arst_n), .pix_ok(take), .pixel_value(pixel_value),
		.cmd(cmd), .sts(sts), .busy_pix(busy_pix), .thr(threshold),
		.dist_out(dist_w)
	);

	pht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_take(take), .end_of_frame(end_of_frame),
		.out_ready(out_ready), .busy_pix(busy_pix), .sts(sts), .cmd(cmd),
		.accepting(accepting), .res_valid(out_valid)
	);

	assign distance_used = 5'(dist_w);
endmodule
